FILE: hw/rtl/ndac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndac_pkg
// Shared types and constants for the neighbour discovery and ARP classifier.
// ----------------------------------------------------------------------------
package ndac_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  // Offset counter saturates at MAX_FRAME_BYTES, so it must hold that value.
  localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
  // A chain boundary plus the largest extension header (256 * 8 bytes).
  localparam int SUM_W = ((OFF_W > 12) ? OFF_W : 12) + 1;

  localparam logic [7:0]  ICMP6_NEXT  = 8'd58;
  localparam int          ETH_HDR_LEN = 14;
  localparam int          IP6_HDR_LEN = 40;
  localparam int          EXT_UNIT    = 8;
  localparam int          ARP_MIN_LEN = 42;
  localparam logic [15:0] TYPE_IPV6   = 16'h86dd;
  localparam logic [15:0] TYPE_ARP    = 16'h0806;
  localparam logic [15:0] TYPE_RARP   = 16'h8035;

  localparam logic [15:0] ARP_OP_REQUEST    = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY      = 16'd2;
  localparam logic [15:0] ARP_OP_RARP_REPLY = 16'd4;

  localparam logic [15:0] ND_ROUTER_SOL  = 16'd133;
  localparam logic [15:0] ND_ROUTER_ADV  = 16'd134;
  localparam logic [15:0] ND_NEIGH_SOL   = 16'd135;
  localparam logic [15:0] ND_NEIGH_ADV   = 16'd136;
  localparam logic [15:0] ND_REDIR       = 16'd137;

  typedef enum logic [3:0] {
    EV_ROUTER_SOL  = 4'd0,
    EV_ROUTER_ADV  = 4'd1,
    EV_NEIGH_SOL   = 4'd2,
    EV_NEIGH_ADV   = 4'd3,
    EV_REDIRECT    = 4'd4,
    EV_OTHER_ICMP6 = 4'd5,
    EV_ARP_REQ     = 4'd6,
    EV_ARP_REPLY   = 4'd7,
    EV_RARP_REPLY  = 4'd8,
    EV_OTHER_OP    = 4'd9,
    EV_SHORT_ARP   = 4'd10
  } event_kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] timestamp;
  } item_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [47:0] source_mac;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [31:0] frame_time;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ndac_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndac_in_stage
// Input register: holds one frame byte until the parser takes it.
// ----------------------------------------------------------------------------
module ndac_in_stage
  import ndac_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ndac_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndac_parser
// Frame state and per-byte parse; classifies the frame on its final byte.
// ----------------------------------------------------------------------------
module ndac_parser
  import ndac_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  take,
  input  wire item_t item,
  output logic       res_valid,
  output result_t    res
);

  logic [OFF_W-1:0] offset_r,   offset_nxt;
  logic [15:0]      ftype_r,    ftype_nxt;
  logic [47:0]      mac_r,      mac_nxt;
  logic [63:0]      addr_hi_r,  addr_hi_nxt;
  logic [63:0]      addr_lo_r,  addr_lo_nxt;
  logic [OFF_W-1:0] bound_r,    bound_nxt;
  logic [7:0]       pend_nh_r,  pend_nh_nxt;
  logic             icmp_r,     icmp_nxt;
  logic [15:0]      msg_r,      msg_nxt;
  logic [31:0]      time_r,     time_nxt;

  logic [OFF_W-1:0] pos;
  logic [7:0]       b;
  logic [SUM_W-1:0] next_bound;
  logic             in_window;
  logic             is_arp;
  event_kind_t      kind;

  always_comb begin
    pos         = offset_r;
    b           = item.data_byte;
    in_window   = offset_r < OFF_W'(MAX_FRAME_BYTES);
    offset_nxt  = offset_r;
    ftype_nxt   = ftype_r;
    mac_nxt     = mac_r;
    addr_hi_nxt = addr_hi_r;
    addr_lo_nxt = addr_lo_r;
    bound_nxt   = bound_r;
    pend_nh_nxt = pend_nh_r;
    icmp_nxt    = icmp_r;
    msg_nxt     = msg_r;
    time_nxt    = time_r;
    next_bound  = SUM_W'(bound_r) + (SUM_W'(b) + SUM_W'(1)) * SUM_W'(EXT_UNIT);

    if (take) begin
      if (offset_r == '0) begin
        ftype_nxt   = '0;
        mac_nxt     = '0;
        addr_hi_nxt = '0;
        addr_lo_nxt = '0;
        bound_nxt   = OFF_W'(MAX_FRAME_BYTES);
        pend_nh_nxt = '0;
        icmp_nxt    = 1'b0;
        msg_nxt     = '0;
        time_nxt    = item.timestamp;
        next_bound  = SUM_W'(MAX_FRAME_BYTES);
      end

      if (in_window) begin
        if (pos >= OFF_W'(6) && pos < OFF_W'(12)) begin
          mac_nxt = {mac_nxt[39:0], b};
        end else if (pos == OFF_W'(12) || pos == OFF_W'(13)) begin
          ftype_nxt = {ftype_nxt[7:0], b};
        end else if (ftype_nxt == TYPE_IPV6) begin
          if (pos == OFF_W'(ETH_HDR_LEN + 6)) begin
            pend_nh_nxt = b;
            bound_nxt   = OFF_W'(ETH_HDR_LEN + IP6_HDR_LEN);
          end else if (pos >= OFF_W'(ETH_HDR_LEN + 8) && pos < OFF_W'(ETH_HDR_LEN + 16)) begin
            addr_hi_nxt = {addr_hi_nxt[55:0], b};
          end else if (pos >= OFF_W'(ETH_HDR_LEN + 16) && pos < OFF_W'(ETH_HDR_LEN + 24)) begin
            addr_lo_nxt = {addr_lo_nxt[55:0], b};
          end
          // Walk the header chain; every header before ICMPv6 counts as an extension.
          if (!icmp_nxt && pos >= OFF_W'(ETH_HDR_LEN + IP6_HDR_LEN)) begin
            if (pos == bound_nxt) begin
              if (pend_nh_nxt == ICMP6_NEXT) begin
                msg_nxt  = {8'd0, b};
                icmp_nxt = 1'b1;
              end else begin
                pend_nh_nxt = b;
              end
            end else if (SUM_W'(pos) == SUM_W'(bound_nxt) + SUM_W'(1)) begin
              if (next_bound >= SUM_W'(MAX_FRAME_BYTES)) begin
                bound_nxt = OFF_W'(MAX_FRAME_BYTES);
              end else begin
                bound_nxt = next_bound[OFF_W-1:0];
              end
            end
          end
        end else if (ftype_nxt == TYPE_ARP || ftype_nxt == TYPE_RARP) begin
          if (pos == OFF_W'(ETH_HDR_LEN + 6) || pos == OFF_W'(ETH_HDR_LEN + 7)) begin
            msg_nxt = {msg_nxt[7:0], b};
          end else if (pos >= OFF_W'(ETH_HDR_LEN + 14) && pos < OFF_W'(ETH_HDR_LEN + 18)) begin
            addr_lo_nxt = {32'd0, addr_lo_nxt[23:0], b};
          end
        end
      end

      if (item.last_byte) begin
        offset_nxt = '0;
      end else if (in_window) begin
        offset_nxt = offset_r + OFF_W'(1);
      end
    end
  end

  // Classification sees the state as updated by the final byte.
  always_comb begin
    is_arp = (ftype_nxt == TYPE_ARP) || (ftype_nxt == TYPE_RARP);
    kind   = EV_OTHER_ICMP6;
    if (ftype_nxt == TYPE_IPV6) begin
      case (msg_nxt)
        ND_ROUTER_SOL: kind = EV_ROUTER_SOL;
        ND_ROUTER_ADV: kind = EV_ROUTER_ADV;
        ND_NEIGH_SOL:  kind = EV_NEIGH_SOL;
        ND_NEIGH_ADV:  kind = EV_NEIGH_ADV;
        ND_REDIR:      kind = EV_REDIRECT;
        default:       kind = EV_OTHER_ICMP6;
      endcase
    end else if (offset_r < OFF_W'(ARP_MIN_LEN - 1)) begin
      kind = EV_SHORT_ARP;
    end else begin
      case (msg_nxt)
        ARP_OP_REQUEST:    kind = EV_ARP_REQ;
        ARP_OP_REPLY:      kind = EV_ARP_REPLY;
        ARP_OP_RARP_REPLY: kind = EV_RARP_REPLY;
        default:           kind = EV_OTHER_OP;
      endcase
    end

    res_valid = take && item.last_byte &&
                (((ftype_nxt == TYPE_IPV6) && icmp_nxt) || is_arp);

    res.event_kind       = kind;
    res.source_mac       = mac_nxt;
    res.source_addr_high = is_arp ? 64'd0 : addr_hi_nxt;
    res.source_addr_low  = (kind == EV_SHORT_ARP) ? 64'd0 : addr_lo_nxt;
    res.frame_time       = time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      ftype_r   <= '0;
      mac_r     <= '0;
      addr_hi_r <= '0;
      addr_lo_r <= '0;
      bound_r   <= '0;
      pend_nh_r <= '0;
      icmp_r    <= 1'b0;
      msg_r     <= '0;
      time_r    <= '0;
    end else begin
      offset_r  <= offset_nxt;
      ftype_r   <= ftype_nxt;
      mac_r     <= mac_nxt;
      addr_hi_r <= addr_hi_nxt;
      addr_lo_r <= addr_lo_nxt;
      bound_r   <= bound_nxt;
      pend_nh_r <= pend_nh_nxt;
      icmp_r    <= icmp_nxt;
      msg_r     <= msg_nxt;
      time_r    <= time_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ndac_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndac_out_stage
// Result register: holds one event until the downstream side takes it.
// ----------------------------------------------------------------------------
module ndac_out_stage
  import ndac_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/neighbor_discovery_arp_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_discovery_arp_classifier_unit
// Classifies Ethernet frames as IPv6 neighbour discovery or ARP/RARP events.
// ----------------------------------------------------------------------------
//  channel | direction | words
//  in_     | slave     | one frame byte per word, tlast on the final byte
//  out_    | master    | one event per classified frame
//
//  One byte is taken every cycle while no final byte waits; out_tvalid rises
//  when the result register is loaded as the parser takes the final byte.
//  Bytes pass an input register, are parsed against the frame state and the
//  event lands in a result register. Only a final byte waits while the result
//  register is full and not being taken. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module neighbor_discovery_arp_classifier_unit
  import ndac_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // data_byte[7:0], timestamp[39:8]
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [215:0]      out_tdata   // event_kind[3:0], source_mac[51:4],
                                        // source_addr_high[115:52],
                                        // source_addr_low[179:116],
                                        // frame_time[211:180], zero above
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign in_item.data_byte = in_tdata[7:0];
  assign in_item.last_byte = in_tlast;
  assign in_item.timestamp = in_tdata[39:8];

  // A final word may need the result register; other words never do.
  assign take = item_valid && (!item.last_byte || out_free);

  ndac_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .take     (take),
    .valid    (item_valid),
    .item     (item)
  );

  ndac_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ndac_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = {4'd0, out_data.frame_time, out_data.source_addr_low,
                      out_data.source_addr_high, out_data.source_mac,
                      out_data.event_kind};

endmodule
`default_nettype wire
